FILE: rtl/mp4_top_level_box_check_core_macros.svh
// Assertion helpers shared by the box scan RTL.
// Both expect clk_i and rst_ni in the scope of the use.
`ifndef MP4_TOP_LEVEL_BOX_CHECK_CORE_MACROS_SVH
`define MP4_TOP_LEVEL_BOX_CHECK_CORE_MACROS_SVH

// Same-cycle implication.
`define MP4BC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MP4BC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mp4bc_pkg.sv
`timescale 1ns / 1ps

package mp4bc_pkg;

  // Configuration port
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_FILE_LENGTH = 2'd0;

  // Default width of file offsets
  localparam int unsigned OFFSET_BITS_DEF = 32;

  // Box types (big-endian four-character codes)
  localparam logic [31:0] TYPE_FTYP = 32'h6674_7970;
  localparam logic [31:0] TYPE_MDAT = 32'h6D64_6174;
  localparam logic [31:0] TYPE_MOOV = 32'h6D6F_6F76;

  // Header lengths in bytes
  localparam logic [4:0] SHORT_HDR = 5'd8;
  localparam logic [4:0] LONG_HDR  = 5'd16;

  // Size field value that announces a 64-bit extended size
  localparam logic [31:0] SIZE_EXTENDED = 32'd1;

  typedef enum logic [1:0] {
    OC_BOTH      = 2'd0,
    OC_NO_ROOM   = 2'd1,
    OC_MALFORMED = 2'd2,
    OC_TRUNCATED = 2'd3
  } outcome_e;

  typedef struct packed {
    logic     playable;
    outcome_e outcome;
  } result_t;

endpackage

FILE: rtl/mp4bc_cfg_regs.sv
`timescale 1ns / 1ps

module mp4bc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mp4bc_pkg::PADDR_W-1:0]   paddr,
  input  logic [mp4bc_pkg::PDATA_W-1:0]   pwdata,
  output logic [mp4bc_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  output logic [31:0]                     file_length_o
);

  logic [mp4bc_pkg::PADDR_W-1:0] reg_idx;
  logic                          hit;
  logic [31:0]                   file_length_q;

  assign reg_idx = paddr >> 2;
  assign hit     = (reg_idx == mp4bc_pkg::REG_FILE_LENGTH);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
    end else if (psel && penable && pwrite && hit) begin
      file_length_q <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = file_length_q;
    end
  end

  assign file_length_o = file_length_q;

endmodule

FILE: rtl/mp4bc_scan.sv
`timescale 1ns / 1ps
`include "mp4_top_level_box_check_core_macros.svh"

module mp4bc_scan #(
  parameter int unsigned OFFSET_BITS = mp4bc_pkg::OFFSET_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic [31:0]        file_length_i,
  output logic               res_valid_o,
  output mp4bc_pkg::result_t res_o
);

  localparam logic [63:0] OffMask = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - OFFSET_BITS);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [3:0]             cnt_q, cnt_d;
  logic [63:0]            hdr_q, hdr_d;
  logic [63:0]            ext_q, ext_d;
  logic [OFFSET_BITS-1:0] box_start_q, box_start_d;
  logic [OFFSET_BITS-1:0] payload_q, payload_d;
  logic                   mdat_q, mdat_d;
  logic                   moov_q, moov_d;

  logic [63:0]            f64, eff64;
  logic [OFFSET_BITS-1:0] eff;
  logic [OFFSET_BITS:0]   diff;
  logic                   past;
  logic [64:0]            room65;
  logic                   no_room_now;
  logic [63:0]            hdr_next, ext_next, hdr_cur;
  logic [4:0]             taken;
  logic [31:0]            size32, box_type;
  logic                   is_long, end_hdr;
  logic [4:0]             hlen;
  logic [63:0]            box_len;
  logic [64:0]            bs65;
  logic                   bad, mdat_n, moov_n, next_no_room;
  logic [OFFSET_BITS-1:0] payload_n, box_start_n, pl_dec;

  // Clip file length to what an offset can hold; room left past box_start.
  assign f64         = {32'd0, file_length_i};
  assign eff64       = (f64 > OffMask) ? OffMask : f64;
  assign eff         = eff64[OFFSET_BITS-1:0];
  assign diff        = {1'b0, eff} - {1'b0, box_start_q};
  assign past        = diff[OFFSET_BITS];
  assign room65      = 65'(diff[OFFSET_BITS-1:0]);
  assign no_room_now = past || (room65 < 65'(mp4bc_pkg::SHORT_HDR));

  // Header bytes with the current byte shifted in; size and type stay put
  // while the extended size bytes arrive.
  assign hdr_next = {hdr_q[55:0], data_byte_i};
  assign ext_next = {ext_q[55:0], data_byte_i};
  assign hdr_cur  = cnt_q[3] ? hdr_q : hdr_next;
  assign taken    = {1'b0, cnt_q} + 5'd1;
  assign size32   = hdr_cur[63:32];
  assign box_type = hdr_cur[31:0];
  assign is_long  = (taken >= mp4bc_pkg::LONG_HDR);
  assign end_hdr  = is_long ||
                    ((taken == mp4bc_pkg::SHORT_HDR) && (size32 != mp4bc_pkg::SIZE_EXTENDED));
  assign hlen     = is_long ? mp4bc_pkg::LONG_HDR : mp4bc_pkg::SHORT_HDR;
  assign box_len  = is_long ? ext_next : {32'd0, size32};
  assign bs65     = {1'b0, box_len};

  assign bad = ((box_start_q == '0) && (box_type != mp4bc_pkg::TYPE_FTYP)) ||
               (box_len < 64'(hlen)) || past || (bs65 > room65);
  assign mdat_n = mdat_q || (box_type == mp4bc_pkg::TYPE_MDAT);
  assign moov_n = moov_q || (box_type == mp4bc_pkg::TYPE_MOOV);

  // Box fits, so the next start stays within the file: room after it is room - size.
  assign next_no_room = room65 < (bs65 + 65'(mp4bc_pkg::SHORT_HDR));
  assign payload_n    = box_len[OFFSET_BITS-1:0] - OFFSET_BITS'(hlen);
  assign box_start_n  = box_start_q + box_len[OFFSET_BITS-1:0];
  assign pl_dec       = (payload_q != '0) ? (payload_q - OFFSET_BITS'(1)) : payload_q;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    hdr_d       = hdr_q;
    ext_d       = ext_q;
    box_start_d = box_start_q;
    payload_d   = payload_q;
    mdat_d      = mdat_q;
    moov_d      = moov_q;
    res_valid_o = 1'b0;
    res_o       = '{playable: 1'b0, outcome: mp4bc_pkg::OC_BOTH};

    case (phase_q)
      PH_HEADER: begin
        if ((cnt_q == '0) && no_room_now) begin
          res_valid_o   = 1'b1;
          res_o.outcome = mp4bc_pkg::OC_NO_ROOM;
          phase_d       = PH_DONE;
        end else begin
          if (!cnt_q[3]) begin
            hdr_d = hdr_next;
          end else begin
            ext_d = ext_next;
          end
          cnt_d = taken[3:0];
          if (end_hdr) begin
            cnt_d = '0;
            if (bad) begin
              res_valid_o   = 1'b1;
              res_o.outcome = mp4bc_pkg::OC_MALFORMED;
              phase_d       = PH_DONE;
            end else begin
              mdat_d = mdat_n;
              moov_d = moov_n;
              if (mdat_n && moov_n) begin
                res_valid_o    = 1'b1;
                res_o.playable = 1'b1;
                res_o.outcome  = mp4bc_pkg::OC_BOTH;
                phase_d        = PH_DONE;
              end else begin
                box_start_d = box_start_n;
                payload_d   = payload_n;
                if (payload_n != '0) begin
                  phase_d = PH_PAYLOAD;
                end else if (next_no_room) begin
                  res_valid_o   = 1'b1;
                  res_o.outcome = mp4bc_pkg::OC_NO_ROOM;
                  phase_d       = PH_DONE;
                end
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        payload_d = pl_dec;
        if (pl_dec == '0) begin
          phase_d = PH_HEADER;
          if (no_room_now) begin
            res_valid_o   = 1'b1;
            res_o.outcome = mp4bc_pkg::OC_NO_ROOM;
            phase_d       = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase

    // End of stream: report truncation if still open, then rearm.
    if (last_byte_i) begin
      if (!res_valid_o && (phase_d != PH_DONE)) begin
        res_valid_o   = 1'b1;
        res_o.outcome = mp4bc_pkg::OC_TRUNCATED;
      end
      phase_d     = PH_HEADER;
      cnt_d       = '0;
      hdr_d       = '0;
      ext_d       = '0;
      box_start_d = '0;
      payload_d   = '0;
      mdat_d      = 1'b0;
      moov_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      cnt_q       <= '0;
      hdr_q       <= '0;
      ext_q       <= '0;
      box_start_q <= '0;
      payload_q   <= '0;
      mdat_q      <= 1'b0;
      moov_q      <= 1'b0;
    end else if (step_en_i) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      hdr_q       <= hdr_d;
      ext_q       <= ext_d;
      box_start_q <= box_start_d;
      payload_q   <= payload_d;
      mdat_q      <= mdat_d;
      moov_q      <= moov_d;
    end
  end

  `MP4BC_ASSERT_NOW(a_payload_nonzero, phase_q == PH_PAYLOAD, payload_q != '0, "payload phase with nothing left")
  `MP4BC_ASSERT_NOW(a_payload_no_hdr, phase_q == PH_PAYLOAD, cnt_q == '0, "header count open during payload")
  `MP4BC_ASSERT_NXT(a_rearm, step_en_i && last_byte_i, (phase_q == PH_HEADER) && (box_start_q == '0) && !mdat_q && !moov_q, "scan not rearmed after last byte")

endmodule

FILE: rtl/mp4_top_level_box_check_core.sv
// Top-level box scan of an MP4 (ISO base media) file, one byte per cycle.
// Input channel: data_byte_i / last_byte_i under in_valid_i / in_ready_o.
// Send the file in order; last_byte_i marks the final byte and rearms the
// scan for the next file. Output channel: playable_o / outcome_o under
// out_valid_o / out_ready_i, at most one verdict per file: both mdat and
// moov seen, no room for another header, malformed box, or truncated.
// Bytes after a verdict are consumed silently until last_byte_i.
// Configuration: APB register file_length at address 0, written between files
// or between requests while nothing is in flight; pready is tied high.
// A verdict shows on out_valid_o once its byte has passed the input register
// and the scan step into the result register.
// Throughput: one byte per cycle while no verdict waits; the scan state
// updates once per byte.
// Stall: while a verdict waits in the result register, one more byte is held
// in the input register; further bytes wait (in_ready_o low).
// Reset (rst_ni low, asynchronous): scan state, file_length, and both
// pipeline valids clear; the block starts in the header phase of a new file.
`timescale 1ns / 1ps
`include "mp4_top_level_box_check_core_macros.svh"

module mp4_top_level_box_check_core #(
  parameter int unsigned OFFSET_BITS = mp4bc_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte stream
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  // verdict
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          playable_o,
  output logic [1:0]                    outcome_o,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mp4bc_pkg::PADDR_W-1:0] paddr,
  input  logic [mp4bc_pkg::PDATA_W-1:0] pwdata,
  output logic [mp4bc_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  logic [31:0]        file_length;

  // input register
  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_last_q;

  // result register
  logic               out_valid_q;
  mp4bc_pkg::result_t out_q;

  logic               advance;
  logic               res_valid;
  mp4bc_pkg::result_t res;

  mp4bc_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .file_length_o (file_length)
  );

  // A byte steps the scan only when a possible verdict has a free slot.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  mp4bc_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (advance),
    .data_byte_i   (in_byte_q),
    .last_byte_i   (in_last_q),
    .file_length_i (file_length),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign playable_o  = out_q.playable;
  assign outcome_o   = out_q.outcome;

  `MP4BC_ASSERT_NOW(a_play_code, out_valid_o, playable_o == (outcome_o == mp4bc_pkg::OC_BOTH), "playable does not match outcome")
  `MP4BC_ASSERT_NXT(a_hold_byte, in_valid_q && !advance, in_valid_q && $stable(in_byte_q) && $stable(in_last_q), "held byte lost or changed")

endmodule
